/* rtl/core/swhr_pkg.sv */
`timescale 1ns / 1ps

package swhr_pkg;

    // Frame geometry
    localparam int unsigned FRAME_W = 40;
    localparam logic [5:0]  FRAME_BITS = 6'd40;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_START_LOW   = 3'd0,
        REG_RELEASE     = 3'd1,
        REG_RESP_TMO    = 3'd2,
        REG_PULSE_CAP   = 3'd3,
        REG_ONE_THRESH  = 3'd4
    } reg_idx_t;

    // Reset values of the configuration registers
    localparam logic [15:0] START_LOW_RST  = 16'd2000;
    localparam logic [7:0]  RELEASE_RST    = 8'd30;
    localparam logic [13:0] RESP_TMO_RST   = 14'd10000;
    localparam logic [7:0]  PULSE_CAP_RST  = 8'd100;
    localparam logic [7:0]  ONE_THRESH_RST = 8'd40;

    // Reading status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TIMEOUT  = 2'd1,
        ST_CHECKSUM = 2'd2
    } status_t;

    // Protocol phases
    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_START_LOW  = 3'd1,
        PH_RELEASE    = 3'd2,
        PH_RESP_HIGH  = 3'd3,
        PH_RESP_LOW   = 3'd4,
        PH_RESP_HIGH2 = 3'd5,
        PH_BIT_WAIT   = 3'd6,
        PH_BIT_HIGH   = 3'd7
    } phase_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [13:0] response_timeout;
        logic [7:0]  pulse_cap;
        logic [7:0]  one_threshold;
    } cfg_t;

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        status_t     status;
        logic [15:0] humidity;
        logic [15:0] temperature;
    } res_t;

endpackage

/* rtl/core/swhr_cfg.sv */
`timescale 1ns / 1ps

module swhr_cfg
    import swhr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    // Write one register per enabled cycle; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks  <= START_LOW_RST;
            cfg_reg.release_ticks    <= RELEASE_RST;
            cfg_reg.response_timeout <= RESP_TMO_RST;
            cfg_reg.pulse_cap        <= PULSE_CAP_RST;
            cfg_reg.one_threshold    <= ONE_THRESH_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_START_LOW:  cfg_reg.start_low_ticks  <= cfg_data;
                REG_RELEASE:    cfg_reg.release_ticks    <= cfg_data[7:0];
                REG_RESP_TMO:   cfg_reg.response_timeout <= cfg_data[13:0];
                REG_PULSE_CAP:  cfg_reg.pulse_cap        <= cfg_data[7:0];
                REG_ONE_THRESH: cfg_reg.one_threshold    <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/swhr_decode.sv */
`timescale 1ns / 1ps

module swhr_decode
    import swhr_pkg::*;
(
    input  logic [FRAME_W-1:0] frame,
    output logic               sum_ok,
    output logic [15:0]        humidity,
    output logic [15:0]        temperature
);

    logic [7:0]  b0, b1, b2, b3, b4;
    logic [7:0]  sum;
    logic [14:0] mag;

    // Split the frame into bytes, first received byte on top
    assign b0 = frame[39:32];
    assign b1 = frame[31:24];
    assign b2 = frame[23:16];
    assign b3 = frame[15:8];
    assign b4 = frame[7:0];

    // Byte-sum checksum, carries dropped
    assign sum    = b0 + b1 + b2 + b3;
    assign sum_ok = (sum == b4);

    assign humidity = {b0, b1};

    // Sign-magnitude to two's complement; negative zero gives zero
    assign mag         = {b2[6:0], b3};
    assign temperature = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};

endmodule

/* rtl/core/swhr_ctrl.sv */
`timescale 1ns / 1ps

module swhr_ctrl
    import swhr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic accept,
    input  logic cmd,
    input  logic pin_level,
    output res_t res
);

    phase_t             phase_reg, phase_next;
    logic [15:0]        tick_reg, tick_next;
    logic [5:0]         bit_idx_reg, bit_idx_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;
    logic [15:0]        hum_reg, hum_next;
    logic [15:0]        temp_reg, temp_next;

    logic [15:0] tick_inc;
    logic [5:0]  bit_idx_inc;
    logic        fail;
    logic        frame_end;
    logic        done;
    status_t     status;
    logic        sum_ok;
    logic [15:0] dec_hum;
    logic [15:0] dec_temp;

    assign tick_inc    = tick_reg + 16'd1;
    assign bit_idx_inc = bit_idx_reg + 6'd1;

    // Decode the frame as it stands after this beat
    swhr_decode u_decode (
        .frame       (frame_next),
        .sum_ok      (sum_ok),
        .humidity    (dec_hum),
        .temperature (dec_temp)
    );

    // Next state
    always_comb
    begin
        logic       fin_bit;
        logic [15:0] meas;

        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        frame_next   = frame_reg;
        fin_bit      = 1'b0;
        fail         = 1'b0;
        meas         = tick_reg;
        frame_end    = 1'b0;

        if (cmd)
        begin
            phase_next   = PH_START_LOW;
            tick_next    = 16'd0;
            bit_idx_next = 6'd0;
            frame_next   = '0;
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: ;
                PH_START_LOW:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.start_low_ticks)
                    begin
                        phase_next = PH_RELEASE;
                        tick_next  = 16'd0;
                    end
                end
                PH_RELEASE:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= {8'd0, cfg.release_ticks})
                    begin
                        phase_next = PH_RESP_HIGH;
                        tick_next  = 16'd0;
                    end
                end
                PH_RESP_HIGH, PH_RESP_HIGH2:
                begin
                    if (pin_level)
                    begin
                        tick_next = tick_inc;
                        fail      = (tick_inc > {2'd0, cfg.response_timeout});
                    end
                    else if (phase_reg == PH_RESP_HIGH)
                    begin
                        phase_next = PH_RESP_LOW;
                        tick_next  = 16'd0;
                    end
                    else
                    begin
                        phase_next   = PH_BIT_WAIT;
                        tick_next    = 16'd0;
                        bit_idx_next = 6'd0;
                        frame_next   = '0;
                    end
                end
                PH_RESP_LOW:
                begin
                    if (!pin_level)
                    begin
                        tick_next = tick_inc;
                        fail      = (tick_inc > {2'd0, cfg.response_timeout});
                    end
                    else
                    begin
                        phase_next = PH_RESP_HIGH2;
                        tick_next  = 16'd0;
                    end
                end
                PH_BIT_WAIT:
                begin
                    if (!pin_level)
                    begin
                        tick_next = tick_inc;
                        fail      = (tick_inc > {2'd0, cfg.response_timeout});
                    end
                    else
                    begin
                        phase_next = PH_BIT_HIGH;
                        tick_next  = 16'd1;
                        meas       = 16'd1;
                        fin_bit    = (cfg.pulse_cap == 8'd0);
                    end
                end
                PH_BIT_HIGH:
                begin
                    if (pin_level)
                    begin
                        tick_next = tick_inc;
                        meas      = tick_inc;
                        fin_bit   = (tick_inc > {8'd0, cfg.pulse_cap});
                    end
                    else
                    begin
                        meas    = tick_reg;
                        fin_bit = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    tick_next  = 16'd0;
                end
            endcase

            // Shift in one measured bit
            if (fin_bit)
            begin
                frame_next   = {frame_reg[FRAME_W-2:0],
                                (meas > {8'd0, cfg.one_threshold})};
                bit_idx_next = bit_idx_inc;
                phase_next   = PH_BIT_WAIT;
                tick_next    = 16'd0;
                frame_end    = (bit_idx_inc >= FRAME_BITS);
            end

            // Close the reading on the last bit
            if (frame_end)
            begin
                phase_next = PH_IDLE;
                tick_next  = 16'd0;
            end

            // Abort on any wait timeout
            if (fail)
            begin
                phase_next = PH_IDLE;
                tick_next  = 16'd0;
            end
        end
    end

    // Flag the end of a reading and its outcome
    always_comb
    begin
        done   = frame_end || fail;
        status = ST_OK;
        if (fail)
            status = ST_TIMEOUT;
        else if (frame_end && !sum_ok)
            status = ST_CHECKSUM;
    end

    // Keep the last good reading
    always_comb
    begin
        hum_next  = hum_reg;
        temp_next = temp_reg;
        if (done && status == ST_OK)
        begin
            hum_next  = dec_hum;
            temp_next = dec_temp;
        end
    end

    // Result fields for this beat
    always_comb
    begin
        res.drive_low   = (phase_next == PH_START_LOW);
        res.busy        = (phase_next != PH_IDLE);
        res.done        = done;
        res.status      = status;
        res.humidity    = hum_next;
        res.temperature = temp_next;
    end

    // Advance state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= 16'd0;
            bit_idx_reg <= 6'd0;
            frame_reg   <= '0;
            hum_reg     <= 16'd0;
            temp_reg    <= 16'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_idx_reg <= bit_idx_next;
            frame_reg   <= frame_next;
            hum_reg     <= hum_next;
            temp_reg    <= temp_next;
        end
    end

endmodule

/* rtl/core/single_wire_humidity_sensor_reader.sv */
`timescale 1ns / 1ps
// Output: a result beat is registered and offered in the cycle after its input beat is taken.
// Throughput: one input beat per cycle while the output is empty or out_ready is high;
// the single output register is refilled in the same cycle it is drained.
// Reset: rst_n clears the phase, counters, frame and last reading, and
// loads the configuration defaults; no result is pending after reset.

module single_wire_humidity_sensor_reader
    import swhr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic               pin_level,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               drive_low,
    output logic               busy_res,
    output logic               done_res,
    output logic [1:0]         status,
    output logic [15:0]        humidity_tenths,
    output logic signed [15:0] temperature_tenths
);

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic out_valid_reg;
    logic accept;

    swhr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    swhr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .cmd       (cmd),
        .pin_level (pin_level),
        .res       (res)
    );

    // Take a beat whenever the output register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Hold the result beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res;
        end
    end

    assign out_valid          = out_valid_reg;
    assign drive_low          = res_reg.drive_low;
    assign busy_res           = res_reg.busy;
    assign done_res           = res_reg.done;
    assign status             = res_reg.status;
    assign humidity_tenths    = res_reg.humidity;
    assign temperature_tenths = res_reg.temperature;

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    import swhr_pkg::*;

    // One tick beat: start command and sampled line level
    typedef struct packed {
        logic cmd;
        logic pin;
    } tick_beat_t;

    // How a queued reading is shaped
    typedef enum int {
        RD_GOOD,
        RD_BAD_SUM,
        RD_TIMEOUT,
        RD_CUT,
        RD_NOISE,
        RD_CAPPED
    } reading_kind_t;

    localparam int NO_BREAK    = 99;
    localparam int STALL_LIMIT = 2000;
    localparam int IDLE_PCT    = 6;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = 1'b0;
    logic               pin_level = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               drive_low;
    logic               busy_res;
    logic               done_res;
    logic [1:0]         status;
    logic [15:0]        humidity_tenths;
    logic signed [15:0] temperature_tenths;

    tick_beat_t pending_ticks[$];
    res_t       expected_readouts[$];
    tick_beat_t next_tick;
    res_t       want;
    logic       steady = 1'b0;
    int         mismatches = 0;
    int         results_seen = 0;
    int         stall_cycles = 0;
    int         queued_items = 0;

    // Shadow of the sensor reader's configuration and state
    cfg_t        shadow_cfg;
    phase_t      sensor_phase = PH_IDLE;
    int unsigned tick_cnt = 0;
    logic [5:0]  bit_cnt = '0;
    logic [39:0] frame_word = '0;
    logic [15:0] last_hum = '0;
    logic [15:0] last_temp = '0;

    single_wire_humidity_sensor_reader DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .cmd                (cmd),
        .pin_level          (pin_level),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .drive_low          (drive_low),
        .busy_res           (busy_res),
        .done_res           (done_res),
        .status             (status),
        .humidity_tenths    (humidity_tenths),
        .temperature_tenths (temperature_tenths)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Validate the received frame and latch the reading when the sum agrees
    function automatic status_t close_frame();
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        logic [7:0]  sum8;
        logic [14:0] mag;
        b0 = frame_word[39:32];
        b1 = frame_word[31:24];
        b2 = frame_word[23:16];
        b3 = frame_word[15:8];
        b4 = frame_word[7:0];
        sensor_phase = PH_IDLE;
        tick_cnt = 0;
        sum8 = b0 + b1 + b2 + b3;
        if (sum8 != b4)
            return ST_CHECKSUM;
        last_hum = {b0, b1};
        mag = {b2[6:0], b3};
        // sign-magnitude to two's complement; negative zero folds to zero
        last_temp = b2[7] ? (16'd0 - {1'b0, mag}) : {1'b0, mag};
        return ST_OK;
    endfunction

    // Shift in one timed bit; true once the whole frame is in
    function automatic logic close_bit();
        frame_word = {frame_word[38:0], (tick_cnt > shadow_cfg.one_threshold)};
        bit_cnt = bit_cnt + 6'd1;
        sensor_phase = PH_BIT_WAIT;
        tick_cnt = 0;
        return bit_cnt >= FRAME_BITS;
    endfunction

    // Advance the shadow reader by one tick and return the readout it gives
    function automatic res_t predict_tick(input logic c, input logic p);
        res_t    r;
        logic    fail;
        logic    done;
        status_t st;
        fail = 1'b0;
        done = 1'b0;
        st = ST_OK;
        if (c)
        begin
            sensor_phase = PH_START_LOW;
            tick_cnt = 0;
            bit_cnt = '0;
            frame_word = '0;
        end
        else
        begin
            case (sensor_phase)
                PH_IDLE:
                    ;
                PH_START_LOW:
                begin
                    tick_cnt++;
                    if (tick_cnt >= shadow_cfg.start_low_ticks)
                    begin
                        sensor_phase = PH_RELEASE;
                        tick_cnt = 0;
                    end
                end
                PH_RELEASE:
                begin
                    tick_cnt++;
                    if (tick_cnt >= shadow_cfg.release_ticks)
                    begin
                        sensor_phase = PH_RESP_HIGH;
                        tick_cnt = 0;
                    end
                end
                PH_RESP_HIGH:
                begin
                    if (p)
                    begin
                        tick_cnt++;
                        fail = tick_cnt > shadow_cfg.response_timeout;
                    end
                    else
                    begin
                        sensor_phase = PH_RESP_LOW;
                        tick_cnt = 0;
                    end
                end
                PH_RESP_LOW:
                begin
                    if (!p)
                    begin
                        tick_cnt++;
                        fail = tick_cnt > shadow_cfg.response_timeout;
                    end
                    else
                    begin
                        sensor_phase = PH_RESP_HIGH2;
                        tick_cnt = 0;
                    end
                end
                PH_RESP_HIGH2:
                begin
                    if (p)
                    begin
                        tick_cnt++;
                        fail = tick_cnt > shadow_cfg.response_timeout;
                    end
                    else
                    begin
                        sensor_phase = PH_BIT_WAIT;
                        tick_cnt = 0;
                        bit_cnt = '0;
                        frame_word = '0;
                    end
                end
                PH_BIT_WAIT:
                begin
                    if (!p)
                    begin
                        tick_cnt++;
                        fail = tick_cnt > shadow_cfg.response_timeout;
                    end
                    else
                    begin
                        sensor_phase = PH_BIT_HIGH;
                        tick_cnt = 1;
                        if (tick_cnt > shadow_cfg.pulse_cap)
                        begin
                            if (close_bit())
                            begin
                                done = 1'b1;
                                st = close_frame();
                            end
                        end
                    end
                end
                PH_BIT_HIGH:
                begin
                    if (p)
                    begin
                        tick_cnt++;
                        if (tick_cnt > shadow_cfg.pulse_cap)
                        begin
                            if (close_bit())
                            begin
                                done = 1'b1;
                                st = close_frame();
                            end
                        end
                    end
                    else if (close_bit())
                    begin
                        done = 1'b1;
                        st = close_frame();
                    end
                end
            endcase
            // any wait phase overrunning its limit drops the reading
            if (fail)
            begin
                sensor_phase = PH_IDLE;
                tick_cnt = 0;
                done = 1'b1;
                st = ST_TIMEOUT;
            end
        end
        r.drive_low = (sensor_phase == PH_START_LOW);
        r.busy = (sensor_phase != PH_IDLE);
        r.done = done;
        r.status = st;
        r.humidity = last_hum;
        r.temperature = last_temp;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 50)
            $display("ERROR readout %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic push_tick(input logic c, input logic p);
        tick_beat_t t;
        t.cmd = c;
        t.pin = p;
        pending_ticks.push_back(t);
        queued_items++;
    endtask

    task automatic push_level(input logic p, input int n);
        repeat (n) push_tick(1'b0, p);
    endtask

    // Queue the ticks of one reading as a sensor would answer it
    task automatic queue_reading(input reading_kind_t kind, input int brk,
                                 input logic [31:0] data);
        logic [39:0] word;
        int          stage;
        int          n;
        int          p;
        int          wait_max;
        int          lim;
        int          cap_lim;
        int          thr_lim;
        int          lead;
        logic        b;
        word = {data, data[31:24] + data[23:16] + data[15:8] + data[7:0]};
        if (kind == RD_BAD_SUM)
            word[7:0] = word[7:0] ^ 8'($urandom_range(1, 255));
        wait_max = shadow_cfg.response_timeout;
        cap_lim = shadow_cfg.pulse_cap;
        thr_lim = shadow_cfg.one_threshold;
        lim = (wait_max < 2) ? wait_max : 2;
        lead = ((shadow_cfg.start_low_ticks == 0) ? 1 : shadow_cfg.start_low_ticks)
             + ((shadow_cfg.release_ticks == 0) ? 1 : shadow_cfg.release_ticks);

        // start command, then the low and release time where the line is ignored
        push_tick(1'b1, 1'($urandom));
        repeat (lead) push_tick(1'b0, 1'($urandom));

        if (kind == RD_NOISE)
        begin
            repeat ($urandom_range(1, 40))
                push_tick(($urandom_range(0, 19) == 0), 1'($urandom));
            return;
        end

        // response high, low, high, then one wait plus one high pulse per bit
        for (stage = 0; stage < 43; stage++)
        begin
            if (kind == RD_CUT && stage == brk)
                return;
            n = (kind == RD_TIMEOUT && stage == brk) ? wait_max + 1 : $urandom_range(0, lim);
            push_level((stage == 0 || stage == 2), n + ((stage != 0) ? 1 : 0));
            if (kind == RD_TIMEOUT && stage == brk)
                return;
            if (stage >= 3)
            begin
                b = word[42 - stage];
                if (kind == RD_CAPPED)
                    p = $urandom_range(1, cap_lim + 3);
                else if (b && thr_lim < cap_lim)
                    p = $urandom_range(thr_lim + 1, cap_lim);
                else if (!b && thr_lim != 0 && cap_lim != 0)
                    p = $urandom_range(1, (thr_lim < cap_lim) ? thr_lim : cap_lim);
                else
                    p = $urandom_range(1, (cap_lim == 0) ? 1 : cap_lim);
                push_level(1'b1, p);
            end
        end
        // falling edge closes the last bit
        push_level(1'b0, 1);
        repeat ($urandom_range(0, 2)) push_tick(1'b0, 1'($urandom));
    endtask

    // Hold until every tick is taken and every readout has come back
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_ticks.size() != 0 || in_valid || expected_readouts.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [15:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_START_LOW:  shadow_cfg.start_low_ticks = val;
            REG_RELEASE:    shadow_cfg.release_ticks = val[7:0];
            REG_RESP_TMO:   shadow_cfg.response_timeout = val[13:0];
            REG_PULSE_CAP:  shadow_cfg.pulse_cap = val[7:0];
            REG_ONE_THRESH: shadow_cfg.one_threshold = val[7:0];
            default:        ;
        endcase
    endtask

    task automatic load_settings(input logic [15:0] start_low, input logic [15:0] release_t,
                                 input logic [15:0] tmo, input logic [15:0] cap,
                                 input logic [15:0] thr);
        wait_drained();
        write_reg(REG_START_LOW, start_low);
        write_reg(REG_RELEASE, release_t);
        write_reg(REG_RESP_TMO, tmo);
        write_reg(REG_PULSE_CAP, cap);
        write_reg(REG_ONE_THRESH, thr);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Driver: offer queued tick beats, hold each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            cmd <= 1'b0;
            pin_level <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_readouts.push_back(predict_tick(cmd, pin_level));
            if (!in_valid || in_ready)
            begin
                if (pending_ticks.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_tick = pending_ticks.pop_front();
                    in_valid <= 1'b1;
                    cmd <= next_tick.cmd;
                    pin_level <= next_tick.pin;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each readout beat against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_readouts.size() == 0)
                    report_mismatch("readout beat with nothing expected");
                else
                begin
                    want = expected_readouts.pop_front();
                    if (drive_low !== want.drive_low)
                        report_mismatch($sformatf("drive_low %b, want %b",
                                                  drive_low, want.drive_low));
                    if (busy_res !== want.busy)
                        report_mismatch($sformatf("busy_res %b, want %b", busy_res, want.busy));
                    if (done_res !== want.done)
                        report_mismatch($sformatf("done_res %b, want %b", done_res, want.done));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
                    if (humidity_tenths !== want.humidity)
                        report_mismatch($sformatf("humidity_tenths %h, want %h",
                                                  humidity_tenths, want.humidity));
                    if (temperature_tenths !== want.temperature)
                        report_mismatch($sformatf("temperature_tenths %h, want %h",
                                                  temperature_tenths, want.temperature));
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAIL single_wire_humidity_sensor_reader");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin : stimulus
        int            phase_no;
        int            pick;
        int            thr;
        reading_kind_t kind;
        phase_no = 0;
        shadow_cfg = {START_LOW_RST, RELEASE_RST, RESP_TMO_RST, PULSE_CAP_RST, ONE_THRESH_RST};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // ticks while idle, then the first ticks of a start at the reset settings and a restart
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_level(1'b1, 12);
        push_tick(1'b1, 1'b1);
        push_level(1'b0, 6);

        // widest register values: only the opening ticks of the long start
        load_settings(16'hFFFF, 16'd255, 16'd16383, 16'd255, 16'd255);
        push_tick(1'b1, 1'($urandom));
        push_level(1'b0, 8);

        // zero registers: one-tick phases, every bit ends on its first high tick
        load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_reading(RD_GOOD, NO_BREAK, $urandom);
        queue_reading(RD_CAPPED, NO_BREAK, $urandom);

        load_settings(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
        queue_reading(RD_GOOD, NO_BREAK, 32'hFFFF_FFFF);

        // typical short settings: negative zero, value extremes, bad sum, restart, timeouts
        load_settings(16'd3, 16'd2, 16'd5, 16'd6, 16'd3);
        queue_reading(RD_GOOD, NO_BREAK, {16'd652, 8'h80, 8'h00});
        queue_reading(RD_GOOD, NO_BREAK, {16'hFFFF, 8'hFF, 8'hFF});
        queue_reading(RD_BAD_SUM, NO_BREAK, $urandom);
        queue_reading(RD_CUT, 12, $urandom);
        queue_reading(RD_TIMEOUT, 1, $urandom);
        queue_reading(RD_TIMEOUT, 20, $urandom);

        // random phases of short settings, mostly well-formed readings
        while (queued_items < 1250)
        begin
            phase_no++;
            thr = $urandom_range(1, 3);
            load_settings($urandom_range(1, 4), $urandom_range(1, 3), $urandom_range(2, 12),
                          thr + $urandom_range(1, 3), thr);
            steady = (phase_no == 1);
            repeat ($urandom_range(1, 2))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    kind = RD_GOOD;
                else if (pick < 65)
                    kind = RD_BAD_SUM;
                else if (pick < 77)
                    kind = RD_TIMEOUT;
                else if (pick < 85)
                    kind = RD_CUT;
                else if (pick < 93)
                    kind = RD_NOISE;
                else
                    kind = RD_CAPPED;
                queue_reading(kind, $urandom_range(0, 42), $urandom);
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("PASS single_wire_humidity_sensor_reader");
        else
            $display("FAIL single_wire_humidity_sensor_reader");
        $finish;
    end

endmodule
